/* hw/rtl/tsrs_pkg.sv */
// Shared types and constants for the timestamp resequencer.
// Depends on nothing; imported by the front end, back end, top level and checker.
package tsrs_pkg;

  localparam int STAMP_W     = 32;
  localparam int DATA_W      = 32;
  // Most releases carried out for one accepted notification
  localparam int MAX_RESULTS = 16;
  localparam logic [STAMP_W-1:0] STAMP_TOP = '1;

  // Object id and payload travel together through the queue and the slot store
  typedef struct packed {
    logic [DATA_W-1:0] object_id;
    logic [DATA_W-1:0] payload;
  } tsrs_data_t;

  // One word of the slot store
  typedef struct packed {
    logic       valid;
    tsrs_data_t data;
  } tsrs_slot_t;

endpackage

/* hw/rtl/tsrs_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tsrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/tsrs_fifo.sv */
// Short queue between the front end and the back end.
// No dependencies; width and depth come from the instantiating module.
module tsrs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [NW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign empty   = (fill == '0);
  assign full    = (fill == NW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rptr];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) wptr <= ptr_inc(wptr);
      if (do_pop)  rptr <= ptr_inc(rptr);
      if (do_push && !do_pop)      fill <= fill + NW'(1);
      else if (do_pop && !do_push) fill <= fill - NW'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= wdata;
    end
  end

endmodule

/* hw/rtl/tsrs_front.sv */
// Front end: takes a notification, checks it against the current stamp
// and works out its slot. Depends on tsrs_pkg.
module tsrs_front import tsrs_pkg::*; #(
  parameter int WINDOW = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [STAMP_W-1:0]        stamp,
  input  logic [DATA_W-1:0]         object_id,
  input  logic [DATA_W-1:0]         payload,
  input  logic [STAMP_W-1:0]        cur,
  input  logic [$clog2(WINDOW)-1:0] cur_idx,
  input  logic                      q_full,
  output logic                      push,
  output logic                      push_store,
  output logic [$clog2(WINDOW)-1:0] push_idx,
  output tsrs_data_t                push_data,
  output logic                      busy
);

  localparam int AW = $clog2(WINDOW);
  localparam int SW = AW + 1;

  // stage A: captured notification
  logic               a_vld;
  logic [STAMP_W-1:0] a_stamp;
  tsrs_data_t         a_data;
  // stage B: classified notification
  logic               b_vld;
  logic               b_store;
  logic [SW-1:0]      b_diff;
  tsrs_data_t         b_data;

  logic               a_adv;
  logic               b_adv;
  logic [STAMP_W:0]   diff_full;
  logic               ahead;
  logic               in_win;
  logic [SW-1:0]      idx_sum;
  logic [SW-1:0]      idx_wrap;

  assign b_adv = b_vld && !q_full;
  assign a_adv = a_vld && (!b_vld || b_adv);
  assign busy  = a_vld || b_vld;

  // window check: strictly ahead and at most WINDOW ahead
  always_comb begin
    diff_full = {1'b0, a_stamp} - {1'b0, cur};
    ahead     = !diff_full[STAMP_W] && (diff_full[STAMP_W-1:0] != '0);
    in_win    = ahead && (diff_full[STAMP_W-1:0] <= STAMP_W'(WINDOW));
  end

  // slot = (cur_idx + distance) mod WINDOW, one compare and subtract
  always_comb begin
    idx_sum  = {1'b0, cur_idx} + b_diff;
    idx_wrap = (idx_sum >= SW'(WINDOW)) ? idx_sum - SW'(WINDOW) : idx_sum;
  end

  assign push       = b_adv;
  assign push_store = b_store;
  assign push_idx   = idx_wrap[AW-1:0];
  assign push_data  = b_data;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else begin
      a_vld <= accept || (a_vld && !a_adv);
      b_vld <= a_adv || (b_vld && !b_adv);
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      a_stamp          <= stamp;
      a_data.object_id <= object_id;
      a_data.payload   <= payload;
    end
    if (a_adv) begin
      b_store <= in_win;
      b_diff  <= diff_full[SW-1:0];
      b_data  <= a_data;
    end
  end

endmodule

/* hw/rtl/tsrs_back.sv */
// Back end: stores in-window notifications in the slot RAM and releases
// consecutive stamps. Depends on tsrs_pkg and tsrs_ram.
module tsrs_back import tsrs_pkg::*; #(
  parameter int WINDOW = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [STAMP_W-1:0]        cfg_data,
  input  logic                      q_empty,
  input  logic                      q_store,
  input  logic [$clog2(WINDOW)-1:0] q_idx,
  input  tsrs_data_t                q_data,
  output logic                      q_pop,
  output logic [STAMP_W-1:0]        cur,
  output logic [$clog2(WINDOW)-1:0] cur_idx,
  output logic                      busy,
  output logic                      out_valid,
  output logic [STAMP_W-1:0]        out_stamp,
  output logic [DATA_W-1:0]         out_object_id,
  output logic [DATA_W-1:0]         out_payload,
  output logic                      last
);

  localparam int AW      = $clog2(WINDOW);
  localparam int CW      = $clog2(MAX_RESULTS + 1);
  localparam int SLOT_W  = $bits(tsrs_slot_t);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ISSUE,
    S_DRAIN
  } state_t;

  state_t             state;
  logic [AW-1:0]      rd_idx;
  logic [CW-1:0]      rel_cnt;
  logic               pend_vld;
  logic [STAMP_W-1:0] pend_stamp;
  tsrs_data_t         pend_data;
  logic [AW-1:0]      clr_cnt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  tsrs_slot_t         ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [SLOT_W-1:0]  ram_rdata;
  tsrs_slot_t         rword;
  logic               release_ok;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] x);
    idx_inc = (x == AW'(WINDOW - 1)) ? '0 : x + AW'(1);
  endfunction

  assign busy    = (state != S_IDLE);
  assign rword   = tsrs_slot_t'(ram_rdata);
  assign release_ok = rword.valid && (rel_cnt != CW'(MAX_RESULTS)) && (cur != STAMP_TOP);

  // slot RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_idx;
    ram_wdata = '0;
    ram_raddr = rd_idx;
    q_pop     = 1'b0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      S_IDLE: begin
        q_pop = !q_empty;
        if (!q_empty && q_store) begin
          ram_we          = 1'b1;
          ram_waddr       = q_idx;
          ram_wdata.valid = 1'b1;
          ram_wdata.data  = q_data;
        end
      end
      S_ISSUE: begin
        ram_raddr = idx_inc(cur_idx);
      end
      S_DRAIN: begin
        if (release_ok) begin
          // retire this slot, fetch the one after it
          ram_we    = 1'b1;
          ram_waddr = rd_idx;
          ram_raddr = idx_inc(rd_idx);
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tsrs_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (WINDOW)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer, stamp state and result register
  // slots are numbered from the start stamp: the start stamp sits at slot 0
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cur       <= '0;
      cur_idx   <= '0;
      clr_cnt   <= '0;
      pend_vld  <= 1'b0;
      out_valid <= 1'b0;
      rel_cnt   <= '0;
      rd_idx    <= '0;
    end else if (cfg_we) begin
      state     <= S_CLEAR;
      cur       <= cfg_data;
      cur_idx   <= '0;
      clr_cnt   <= '0;
      pend_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(WINDOW - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          rd_idx  <= idx_inc(cur_idx);
          rel_cnt <= '0;
          state   <= S_DRAIN;
        end
        S_DRAIN: begin
          if (release_ok) begin
            cur        <= cur + STAMP_W'(1);
            cur_idx    <= rd_idx;
            rd_idx     <= idx_inc(rd_idx);
            rel_cnt    <= rel_cnt + CW'(1);
            pend_vld   <= 1'b1;
            pend_stamp <= cur + STAMP_W'(1);
            pend_data  <= rword.data;
            // a further release follows, so the held one is not the last
            if (pend_vld) begin
              out_valid     <= 1'b1;
              out_stamp     <= pend_stamp;
              out_object_id <= pend_data.object_id;
              out_payload   <= pend_data.payload;
              last          <= 1'b0;
            end
          end else begin
            if (pend_vld) begin
              out_valid     <= 1'b1;
              out_stamp     <= pend_stamp;
              out_object_id <= pend_data.object_id;
              out_payload   <= pend_data.payload;
              last          <= 1'b1;
            end
            pend_vld <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/timestamp_resequencer.sv */
// Top level of the timestamp resequencer: front end, queue and back end.
// Depends on tsrs_pkg, tsrs_front, tsrs_fifo, tsrs_back (and tsrs_ram below it).
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  input    | start & !busy             | stamp, object_id, payload
//  config   | cfg_valid & cfg_ready     | cfg_data (start stamp)
//  result   | out_valid, one cycle      | out_stamp, out_object_id, out_payload, last
//
// A notification passes front stages A and B and the queue, then store, slot read
// and check in the back end, which reads the single slot RAM port once per release.
// Reset and every config write run a clearing pass over all WINDOW slots (slot
// valid bits cleared, slots numbered from the start stamp);
// busy is high throughout. The receiver cannot stall: results are strobed.
module timestamp_resequencer import tsrs_pkg::*; #(
  parameter int WINDOW = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [STAMP_W-1:0] stamp,
  input  logic [DATA_W-1:0]  object_id,
  input  logic [DATA_W-1:0]  payload,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [STAMP_W-1:0] cfg_data,
  output logic               out_valid,
  output logic [STAMP_W-1:0] out_stamp,
  output logic [DATA_W-1:0]  out_object_id,
  output logic [DATA_W-1:0]  out_payload,
  output logic               last
);

  localparam int AW = $clog2(WINDOW);
  localparam int QW = 1 + AW + $bits(tsrs_data_t);
  localparam int QDEPTH = 2;

  logic               accept;
  logic               cfg_we;
  logic               front_busy;
  logic               back_busy;
  logic [STAMP_W-1:0] cur;
  logic [AW-1:0]      cur_idx;

  logic               push;
  logic               push_store;
  logic [AW-1:0]      push_idx;
  tsrs_data_t         push_data;
  logic               q_pop;
  logic               q_empty;
  logic               q_full;
  logic [QW-1:0]      q_wdata;
  logic [QW-1:0]      q_rdata;
  logic               q_store;
  logic [AW-1:0]      q_idx;
  tsrs_data_t         q_data;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign accept    = start && !busy;
  assign busy      = front_busy || !q_empty || back_busy;

  assign q_wdata = {push_store, push_idx, push_data};
  assign {q_store, q_idx, q_data} = q_rdata;

  tsrs_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .stamp      (stamp),
    .object_id  (object_id),
    .payload    (payload),
    .cur        (cur),
    .cur_idx    (cur_idx),
    .q_full     (q_full),
    .push       (push),
    .push_store (push_store),
    .push_idx   (push_idx),
    .push_data  (push_data),
    .busy       (front_busy)
  );

  tsrs_fifo #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  tsrs_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .q_empty       (q_empty),
    .q_store       (q_store),
    .q_idx         (q_idx),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .cur           (cur),
    .cur_idx       (cur_idx),
    .busy          (back_busy),
    .out_valid     (out_valid),
    .out_stamp     (out_stamp),
    .out_object_id (out_object_id),
    .out_payload   (out_payload),
    .last          (last)
  );

endmodule

/* hw/rtl/tsrs_checker.sv */
// Port-level checks for the timestamp resequencer, bound to the top level.
// Depends on tsrs_pkg and timestamp_resequencer.
module tsrs_checker import tsrs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic               out_valid,
  input logic [STAMP_W-1:0] out_stamp,
  input logic               last
);

  // a non-final release is followed at once by the next consecutive stamp
  a_consecutive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last && !(cfg_valid && cfg_ready)) |=>
      (out_valid && (out_stamp == $past(out_stamp) + STAMP_W'(1))))
    else $error("release stamps not consecutive");

  // a drain in progress keeps the block busy
  a_busy_in_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> busy)
    else $error("busy low in the middle of a drain");

  // clearing pass after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> busy)
    else $error("not busy after reset");

  // a config transfer starts a clearing pass and cancels pending results
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (busy && !out_valid))
    else $error("config transfer did not restart the clearing pass");

  // an accepted notification keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low right after a transfer");

endmodule

bind timestamp_resequencer tsrs_checker u_chk (.*);
